// ===== src/bpa_pkg.sv =====
// Shared types, constants and codes for the bitmap page allocator.
package bpa_pkg;

  localparam int DEF_BITMAP_WORDS = 16;
  localparam int DEF_PAGE_SHIFT   = 12;
  localparam int WORD_BITS        = 64;
  localparam int ADDR_W           = 64;
  localparam int COUNT_W          = 11;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 64;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PAGE_LIMIT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 1'b1;

  // Input opcodes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  // Bitmap read address source
  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_NEXT = 2'd1,
    RD_REL  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    clr_write;
    logic    ptr_clear;
    logic    ptr_inc;
    rd_sel_t rd_sel;
    logic    capture;
    logic    acq_commit;
    logic    rel_calc;
    logic    rel_commit;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic limit_reached;
    logic word_full;
    logic ptr_last;
    logic rel_bad;
    logic bit_clear;
    logic out_free;
  } stat_t;

endpackage

// ===== src/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bpa_ctrl.sv =====
// Sequencer for clearing, acquire scan, release and result hand-off.
module bpa_ctrl import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  opcode,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_stall
);

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_ACQ       = 8'b0000_0100,
    S_SCAN      = 8'b0000_1000,
    S_REL_CALC  = 8'b0001_0000,
    S_REL_READ  = 8'b0010_0000,
    S_REL_CHECK = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.ptr_last) begin
          cmd.ptr_clear = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (opcode == OP_RELEASE) ? S_REL_CALC : S_ACQ;
        end
      end
      S_ACQ: begin
        if (stat.limit_reached) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
          state_next     = S_RESP;
        end else begin
          cmd.ptr_clear = 1'b1;
          cmd.rd_sel    = RD_ZERO;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.word_full) begin
          cmd.acq_commit = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_GRANTED;
          state_next     = S_RESP;
        end else if (stat.ptr_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
          state_next     = S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          cmd.rd_sel  = RD_NEXT;
        end
      end
      S_REL_CALC: begin
        cmd.rel_calc = 1'b1;
        state_next   = S_REL_READ;
      end
      S_REL_READ: begin
        if (stat.rel_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_IGNORED;
          state_next     = S_RESP;
        end else begin
          cmd.rd_sel = RD_REL;
          state_next = S_REL_CHECK;
        end
      end
      S_REL_CHECK: begin
        cmd.res_load = 1'b1;
        if (stat.bit_clear) begin
          cmd.res_status = ST_IGNORED;
        end else begin
          cmd.rel_commit = 1'b1;
          cmd.res_status = ST_RELEASED;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/bpa_datapath.sv =====
// Bitmap storage, counters, address arithmetic and output register.
module bpa_datapath import bpa_pkg::*; #(
  parameter int BITMAP_WORDS = DEF_BITMAP_WORDS,
  parameter int PAGE_SHIFT   = DEF_PAGE_SHIFT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [ADDR_W-1:0]      address,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [ADDR_W-1:0]      page_address,
  output logic [1:0]             status
);

  localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int IW = WW + BW;
  localparam logic [ADDR_W-1:0] PAGE_CAP  = ADDR_W'(BITMAP_WORDS) * ADDR_W'(WORD_BITS);
  localparam logic [WW-1:0]     LAST_WORD = WW'(BITMAP_WORDS - 1);

  logic [COUNT_W-1:0]   page_limit;
  logic [ADDR_W-1:0]    base_address;
  logic [COUNT_W-1:0]   used_count;
  logic [ADDR_W-1:0]    addr_q;
  logic [WW-1:0]        ptr;
  logic [WW-1:0]        rel_word;
  logic [BW-1:0]        rel_bit;
  logic                 rel_bad;
  logic [IW-1:0]        res_idx;
  status_t              res_status;

  logic                 ram_we;
  logic [WW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [BW-1:0]        free_bit;
  logic [ADDR_W-1:0]    rel_diff;
  logic [ADDR_W-1:0]    rel_pidx;

  function automatic logic [BW-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BW-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BW'(i);
      end
    end
    return pos;
  endfunction

  bpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(BITMAP_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign free_bit = first_zero(ram_rdata);
  assign rel_diff = addr_q - base_address;
  assign rel_pidx = rel_diff >> PAGE_SHIFT;

  always_comb begin
    case (cmd.rd_sel)
      RD_NEXT: ram_raddr = (ptr == LAST_WORD) ? ptr : ptr + WW'(1);
      RD_REL:  ram_raddr = rel_word;
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = cmd.clr_write | cmd.acq_commit | cmd.rel_commit;
    ram_waddr = ptr;
    ram_wdata = '0;
    if (cmd.acq_commit) begin
      ram_wdata = ram_rdata | (WORD_BITS'(1) << free_bit);
    end else if (cmd.rel_commit) begin
      ram_waddr = rel_word;
      ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rel_bit);
    end
  end

  always_comb begin
    stat.limit_reached = (used_count >= page_limit);
    stat.word_full     = &ram_rdata;
    stat.ptr_last      = (ptr == LAST_WORD);
    stat.rel_bad       = rel_bad;
    stat.bit_clear     = !ram_rdata[rel_bit];
    stat.out_free      = !out_valid || !out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit   <= LIMIT_RESET;
      base_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAGE_LIMIT:   page_limit   <= cfg_data[COUNT_W-1:0];
        REG_BASE_ADDRESS: base_address <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.ptr_clear) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + WW'(1);
      end
      if (cmd.acq_commit) begin
        used_count <= used_count + COUNT_W'(1);
      end else if (cmd.rel_commit && (used_count != '0)) begin
        used_count <= used_count - COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= address;
    end
    if (cmd.rel_calc) begin
      rel_word <= rel_pidx[IW-1:BW];
      rel_bit  <= rel_pidx[BW-1:0];
      rel_bad  <= (addr_q < base_address) || (rel_pidx >= PAGE_CAP);
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_idx    <= {ptr, free_bit};
    end
    if (cmd.out_load) begin
      status       <= res_status;
      page_address <= (res_status == ST_GRANTED) ?
                      base_address + (ADDR_W'(res_idx) << PAGE_SHIFT) : '0;
    end
  end

endmodule

// ===== src/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap first-fit page allocator.
//
// Input channel (in_valid / in_stall, opcode, address): one transaction per
// request, acquire or release. Output channel (out_valid / out_stall,
// page_address, status): exactly one transaction per request, in order.
// Configuration (cfg_we, cfg_index, cfg_data) writes page_limit (index 0)
// or base_address (index 1); write only while idle.
//
// One request is in flight at a time; in_stall is high from acceptance
// until the result moves into the output register. An acquire checks the
// limit, then scans k = 1..BITMAP_WORDS words from word 0, the scan loop
// reading one bitmap word per cycle from the RAM read port; an acquire
// refused by the limit skips the scan. A release subtracts the address,
// reads the word and does a read-modify-write; one rejected by range ends
// after the subtract. The output register frees the front end, so the next
// request is taken while a result still waits on out_stall; a stalled
// result holds.
// After reset a clearing pass writes every bitmap word to zero, one word a
// cycle, with in_stall high; configuration writes are taken during the
// pass. Reset sets page_limit to 1024, base to zero.
module bitmap_page_allocator_unit import bpa_pkg::*; #(
  parameter int BITMAP_WORDS = DEF_BITMAP_WORDS,
  parameter int PAGE_SHIFT   = DEF_PAGE_SHIFT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic [ADDR_W-1:0]      address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ADDR_W-1:0]      page_address,
  output logic [1:0]             status
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the clear pass, scan and release steps
  bpa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .opcode  (opcode),
    .stat    (stat),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  // Hold the bitmap, count, config and result registers
  bpa_datapath #(
    .BITMAP_WORDS(BITMAP_WORDS),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .address     (address),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .page_address(page_address),
    .status      (status)
  );

endmodule

// ===== src/bpa_checker.sv =====
// Port-level assertions for the page allocator, bound to the top level.
module bpa_checker import bpa_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [ADDR_W-1:0]      page_address,
  input logic [1:0]             status
);

  // Clear pass keeps the front end closed and no result pending
  a_reset_quiet: assert property (@(posedge clk) rst |=> in_stall && !out_valid)
    else $error("allocator not quiet after reset");

  // One request at a time: acceptance closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted while one is in flight");

  // Only a grant carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_GRANTED)) |-> (page_address == '0))
    else $error("non-grant result with nonzero address");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(page_address) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);
